// ===== hdl/ssvf_pkg.sv =====
// Shared types and constants for the stereo state-variable filter.
// Holds register indices, output modes, sequencer state and step codes, post-add controls and datapath widths.
// No dependencies.
package ssvf_pkg;

    localparam int MUL_A_W = 34;
    localparam int MUL_B_W = 33;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int ADD_W   = 48;
    localparam int SUM_W   = PROD_W + 1;

    localparam logic signed [MUL_B_W-1:0] TUNE_COEF_Q32 = 33'sd152982;

    localparam logic [2:0] REG_CUTOFF    = 3'd0;
    localparam logic [2:0] REG_RESONANCE = 3'd1;
    localparam logic [2:0] REG_LFO1_RATE = 3'd2;
    localparam logic [2:0] REG_LFO1_DEPTH = 3'd3;
    localparam logic [2:0] REG_LFO2_RATE = 3'd4;
    localparam logic [2:0] REG_LFO2_DEPTH = 3'd5;
    localparam logic [2:0] REG_DRY_GAIN  = 3'd6;
    localparam logic [2:0] REG_MODE      = 3'd7;

    localparam logic [1:0] MODE_LOW  = 2'd0;
    localparam logic [1:0] MODE_HIGH = 2'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_SUM,
        ST_FIN
    } state_t;

    typedef enum logic [3:0] {
        STEP_L1C,
        STEP_L1S,
        STEP_L2C,
        STEP_L2S,
        STEP_COEF,
        STEP_LOW,
        STEP_HIGH,
        STEP_BAND,
        STEP_DRY
    } step_t;

    typedef enum logic [1:0] {
        SH_14,
        SH_18,
        SH_24,
        SH_30
    } shift_t;

    typedef struct packed {
        shift_t shift;
        logic   neg_prod;
        logic   neg_add;
    } post_t;

endpackage

// ===== hdl/stereo_svf_with_dual_lfo.sv =====
// Stereo state-variable filter with two quadrature LFOs, top level.
// A new pair is taken only in idle, so no pair is accepted until the last result is in the output register.
// One shared multiplier steps through 13 products per pair, each in a multiply state then an accumulate state.
// Reset (aresetn, synchronous, active low) loads default registers and zero state.
// Depends on ssvf_pkg and ssvf_mac.
module stereo_svf_with_dual_lfo #(
    parameter int SAMPLE_WIDTH = 24
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic                                      cfg_we,
    input  logic [2:0]                                cfg_index,
    input  logic [23:0]                               cfg_data,
    input  logic                                      s_tvalid,
    output logic                                      s_tready,
    // left_sample, right_sample, zero pad
    input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]       s_tdata,
    output logic                                      m_tvalid,
    input  logic                                      m_tready,
    // left_result, right_result, zero pad
    output logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]       m_tdata
);
    import ssvf_pkg::*;

    localparam int DATA_W = ((2*SAMPLE_WIDTH+7)/8)*8;
    localparam int PAD_W  = DATA_W - 2*SAMPLE_WIDTH;
    localparam int FRAC   = SAMPLE_WIDTH - 4;
    localparam int UP     = (FRAC >= 16) ? FRAC - 16 : 0;
    localparam int DN     = (FRAC >= 16) ? 0 : 16 - FRAC;

    state_t state_reg, state_next;
    step_t  step_reg, step_next;
    logic   ch_reg, ch_next;

    logic [14:0]        cutoff_reg;
    logic [15:0]        res_gain_reg;
    logic [23:0]        rate1_reg, rate2_reg;
    logic signed [15:0] dry_reg;
    logic [1:0]         mode_reg;

    logic signed [31:0] s1_reg, c1_reg, s2_reg, c2_reg;
    logic signed [31:0] low_l_reg, band_l_reg, low_r_reg, band_r_reg;
    logic signed [31:0] f_reg, high_reg;
    logic signed [MUL_A_W-1:0] sum_reg;

    logic signed [SAMPLE_WIDTH-1:0] in_l_reg, in_r_reg;
    logic signed [SAMPLE_WIDTH-1:0] res_l_reg, res_r_reg;
    logic                           m_valid_reg;
    logic [DATA_W-1:0]              m_data_reg;

    logic signed [31:0]             low_cur, band_cur, sel_cur;
    logic signed [SAMPLE_WIDTH-1:0] in_cur;
    logic signed [MUL_A_W-1:0]      in_ext, x_val, diff;
    logic signed [ADD_W-1:0]        sel_q;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    post_t                     post;
    logic signed [ADD_W-1:0]   addend;
    logic signed [31:0]        res_word;
    logic signed [SAMPLE_WIDTH-1:0] res_sample;
    logic                      out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign out_free = !m_valid_reg || m_tready;

    assign low_cur  = ch_reg ? low_r_reg : low_l_reg;
    assign band_cur = ch_reg ? band_r_reg : band_l_reg;
    assign in_cur   = ch_reg ? in_r_reg : in_l_reg;
    assign in_ext   = MUL_A_W'(in_cur);
    assign x_val    = (in_ext >>> UP) <<< DN;
    assign diff     = x_val - MUL_A_W'(band_cur);

    always_comb begin
        case (mode_reg)
            MODE_LOW:  sel_cur = low_cur;
            MODE_HIGH: sel_cur = high_reg;
            default:   sel_cur = band_cur;
        endcase
        sel_q = (ADD_W'(sel_cur) <<< UP) >>> DN;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        ch_next    = ch_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_MUL;
                    step_next  = STEP_L1C;
                    ch_next    = 1'b0;
                end
            end
            ST_MUL: begin
                state_next = ST_ACC;
            end
            ST_ACC: begin
                state_next = ST_MUL;
                case (step_reg)
                    STEP_L1C:  step_next = STEP_L1S;
                    STEP_L1S:  step_next = STEP_L2C;
                    STEP_L2C:  step_next = STEP_L2S;
                    STEP_L2S:  state_next = ST_SUM;
                    STEP_COEF: step_next = STEP_LOW;
                    STEP_LOW:  step_next = STEP_HIGH;
                    STEP_HIGH: step_next = STEP_BAND;
                    STEP_BAND: step_next = STEP_DRY;
                    STEP_DRY: begin
                        if (ch_reg) begin
                            state_next = ST_FIN;
                        end else begin
                            ch_next   = 1'b1;
                            step_next = STEP_LOW;
                        end
                    end
                    default: state_next = ST_IDLE;
                endcase
            end
            ST_SUM: begin
                state_next = ST_MUL;
                step_next  = STEP_COEF;
            end
            ST_FIN: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // operand and post-add selection
    always_comb begin
        mul_a         = '0;
        mul_b         = '0;
        post.shift    = SH_30;
        post.neg_prod = 1'b0;
        post.neg_add  = 1'b0;
        addend        = '0;
        case (step_reg)
            STEP_L1C: begin
                mul_a = MUL_A_W'(s1_reg);
                mul_b = $signed(MUL_B_W'(rate1_reg));
                post.shift    = SH_24;
                post.neg_prod = 1'b1;
                addend        = ADD_W'(c1_reg);
            end
            STEP_L1S: begin
                mul_a = MUL_A_W'(c1_reg);
                mul_b = $signed(MUL_B_W'(rate1_reg));
                post.shift = SH_24;
                addend     = ADD_W'(s1_reg);
            end
            STEP_L2C: begin
                mul_a = MUL_A_W'(s2_reg);
                mul_b = $signed(MUL_B_W'(rate2_reg));
                post.shift    = SH_24;
                post.neg_prod = 1'b1;
                addend        = ADD_W'(c2_reg);
            end
            STEP_L2S: begin
                mul_a = MUL_A_W'(c2_reg);
                mul_b = $signed(MUL_B_W'(rate2_reg));
                post.shift = SH_24;
                addend     = ADD_W'(s2_reg);
            end
            STEP_COEF: begin
                mul_a      = sum_reg;
                mul_b      = TUNE_COEF_Q32;
                post.shift = SH_18;
            end
            STEP_LOW: begin
                mul_a      = MUL_A_W'(f_reg);
                mul_b      = MUL_B_W'(band_cur);
                post.shift = SH_30;
                addend     = ADD_W'(low_cur);
            end
            STEP_HIGH: begin
                mul_a        = diff;
                mul_b        = $signed(MUL_B_W'(res_gain_reg));
                post.shift   = SH_14;
                post.neg_add = 1'b1;
                addend       = ADD_W'(low_cur);
            end
            STEP_BAND: begin
                mul_a      = MUL_A_W'(f_reg);
                mul_b      = MUL_B_W'(high_reg);
                post.shift = SH_30;
                addend     = ADD_W'(band_cur);
            end
            STEP_DRY: begin
                mul_a      = MUL_A_W'(dry_reg);
                mul_b      = MUL_B_W'(in_cur);
                post.shift = SH_14;
                addend     = sel_q;
            end
            default: begin
                mul_a = '0;
            end
        endcase
    end

    ssvf_mac #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_mac (
        .aclk       (aclk),
        .mul_a      (mul_a),
        .mul_b      (mul_b),
        .post       (post),
        .addend     (addend),
        .res_word   (res_word),
        .res_sample (res_sample)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= STEP_L1C;
            ch_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            ch_reg    <= ch_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cutoff_reg   <= 15'd1000;
            res_gain_reg <= 16'd16384;
            rate1_reg    <= '0;
            rate2_reg    <= '0;
            dry_reg      <= '0;
            mode_reg     <= MODE_LOW;
            s1_reg       <= '0;
            c1_reg       <= '0;
            s2_reg       <= '0;
            c2_reg       <= '0;
            low_l_reg    <= '0;
            band_l_reg   <= '0;
            low_r_reg    <= '0;
            band_r_reg   <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_CUTOFF:     cutoff_reg   <= cfg_data[14:0];
                REG_RESONANCE:  res_gain_reg <= cfg_data[15:0];
                REG_LFO1_RATE:  rate1_reg    <= cfg_data;
                REG_LFO1_DEPTH: c1_reg       <= {cfg_data[15:0], 16'h0000};
                REG_LFO2_RATE:  rate2_reg    <= cfg_data;
                REG_LFO2_DEPTH: c2_reg       <= {cfg_data[15:0], 16'h0000};
                REG_DRY_GAIN:   dry_reg      <= cfg_data[15:0];
                REG_MODE:       mode_reg     <= cfg_data[1:0];
                default:        mode_reg     <= mode_reg;
            endcase
        end else if (state_reg == ST_ACC) begin
            case (step_reg)
                STEP_L1C: c1_reg <= res_word;
                STEP_L1S: s1_reg <= res_word;
                STEP_L2C: c2_reg <= res_word;
                STEP_L2S: s2_reg <= res_word;
                STEP_LOW: begin
                    if (ch_reg) begin
                        low_r_reg <= res_word;
                    end else begin
                        low_l_reg <= res_word;
                    end
                end
                STEP_BAND: begin
                    if (ch_reg) begin
                        band_r_reg <= res_word;
                    end else begin
                        band_l_reg <= res_word;
                    end
                end
                default: s1_reg <= s1_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_l_reg <= s_tdata[SAMPLE_WIDTH-1:0];
            in_r_reg <= s_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];
        end
        if (state_reg == ST_SUM) begin
            sum_reg <= MUL_A_W'(s1_reg) + MUL_A_W'(s2_reg)
                       + $signed(MUL_A_W'({cutoff_reg, 16'h0000}));
        end
        if (state_reg == ST_ACC) begin
            case (step_reg)
                STEP_COEF: f_reg    <= res_word;
                STEP_HIGH: high_reg <= res_word;
                STEP_DRY: begin
                    if (ch_reg) begin
                        res_r_reg <= res_sample;
                    end else begin
                        res_l_reg <= res_sample;
                    end
                end
                default: f_reg <= f_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == ST_FIN && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_FIN && out_free) begin
            m_data_reg <= {{PAD_W{1'b0}}, res_r_reg, res_l_reg};
        end
    end

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> state_reg == ST_MUL && step_reg == STEP_L1C && !ch_reg)
        else $error("input transfer did not start the step sequence");

    a_fin_delivers: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_FIN && out_free |=> m_tvalid && state_reg == ST_IDLE)
        else $error("finished pair not moved into the output register");

    a_right_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_ACC && step_reg == STEP_DRY && !ch_reg
        |=> ch_reg && step_reg == STEP_LOW && state_reg == ST_MUL)
        else $error("right channel did not follow the left channel");

endmodule

// ===== hdl/ssvf_mac.sv =====
// Shared multiply and post-add unit of the stereo state-variable filter.
// Registers one signed product, then shifts, adds and saturates it.
// Depends on ssvf_pkg.
module ssvf_mac #(
    parameter int SAMPLE_WIDTH = 24
) (
    input  logic                                  aclk,
    input  logic signed [ssvf_pkg::MUL_A_W-1:0]   mul_a,
    input  logic signed [ssvf_pkg::MUL_B_W-1:0]   mul_b,
    input  ssvf_pkg::post_t                       post,
    input  logic signed [ssvf_pkg::ADD_W-1:0]     addend,
    output logic signed [31:0]                    res_word,
    output logic signed [SAMPLE_WIDTH-1:0]        res_sample
);
    import ssvf_pkg::*;

    localparam logic signed [SUM_W-1:0] WORD_MAX =
        $signed({{(SUM_W-31){1'b0}}, {31{1'b1}}});
    localparam logic signed [SUM_W-1:0] WORD_MIN = ~WORD_MAX;
    localparam logic signed [SUM_W-1:0] SMP_MAX =
        $signed({{(SUM_W-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}});
    localparam logic signed [SUM_W-1:0] SMP_MIN = ~SMP_MAX;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] shifted;
    logic signed [SUM_W-1:0]  prod_term;
    logic signed [SUM_W-1:0]  add_term;
    logic signed [SUM_W-1:0]  total;

    always_ff @(posedge aclk) begin
        prod_reg <= PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    always_comb begin
        case (post.shift)
            SH_14:   shifted = prod_reg >>> 14;
            SH_18:   shifted = prod_reg >>> 18;
            SH_24:   shifted = prod_reg >>> 24;
            SH_30:   shifted = prod_reg >>> 30;
            default: shifted = prod_reg >>> 30;
        endcase
        prod_term = post.neg_prod ? -SUM_W'(shifted) : SUM_W'(shifted);
        add_term  = post.neg_add ? -SUM_W'(addend) : SUM_W'(addend);
        total     = prod_term + add_term;
    end

    always_comb begin
        if (total > WORD_MAX) begin
            res_word = WORD_MAX[31:0];
        end else if (total < WORD_MIN) begin
            res_word = WORD_MIN[31:0];
        end else begin
            res_word = total[31:0];
        end
        if (total > SMP_MAX) begin
            res_sample = SMP_MAX[SAMPLE_WIDTH-1:0];
        end else if (total < SMP_MIN) begin
            res_sample = SMP_MIN[SAMPLE_WIDTH-1:0];
        end else begin
            res_sample = total[SAMPLE_WIDTH-1:0];
        end
    end

endmodule

// ===== sim/tb_top.sv =====
// Self-checking bench for stereo_svf_with_dual_lfo: directed table, then random phases.
// Predicts every filtered pair in fixed point and compares it with each result transfer.
// Depends on ssvf_pkg and the RTL under hdl.
module tb_top;
    import ssvf_pkg::*;

    localparam int           LIMIT         = 600_000;
    localparam logic [1:0]   MODE_BAND     = 2'd2;
    localparam logic [1:0]   MODE_BAND_ALT = 2'd3;
    localparam logic [23:0]  S_MAX         = 24'h7FFFFF;
    localparam logic [23:0]  S_MIN         = 24'h800000;
    localparam longint       Q32_MAX       = 64'sd2147483647;
    localparam longint       Q32_MIN       = -64'sd2147483648;
    localparam longint       SMP_MAX       = 64'sd8388607;
    localparam longint       SMP_MIN       = -64'sd8388608;

    typedef enum {ROW_CFG, ROW_PAIR} row_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic [2:0]  idx;
        logic [23:0] value;
        logic [47:0] data;
        bit          typed;
        logic [47:0] known;
    } dir_row_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [2:0]  cfg_index = 3'd0;
    logic [23:0] cfg_data  = 24'd0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata   = 48'd0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [47:0] m_tdata;

    // filter settings and state as the predictor sees them
    logic        [14:0] cut_hz   = 15'd1000;
    logic        [15:0] res_gain = 16'd16384;
    logic        [23:0] rate_one = 24'd0;
    logic        [23:0] rate_two = 24'd0;
    logic signed [15:0] dry_q14  = 16'sd0;
    logic        [1:0]  out_mode = MODE_LOW;
    logic signed [31:0] sin_one  = 32'sd0;
    logic signed [31:0] cos_one  = 32'sd0;
    logic signed [31:0] sin_two  = 32'sd0;
    logic signed [31:0] cos_two  = 32'sd0;
    logic signed [31:0] low_l    = 32'sd0;
    logic signed [31:0] band_l   = 32'sd0;
    logic signed [31:0] low_r    = 32'sd0;
    logic signed [31:0] band_r   = 32'sd0;

    logic [47:0] awaited_pairs[$];
    dir_row_t    plan[$];
    logic [47:0] want_pair;
    int          errors         = 0;
    int          results_seen   = 0;
    int          hold_left      = 0;
    int          stall_left     = 0;
    int          calm_left      = 0;
    bit          long_hold_done = 1'b0;
    int          cycles         = 0;

    stereo_svf_with_dual_lfo #(
        .SAMPLE_WIDTH(24)
    ) u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > Q32_MAX) return Q32_MAX[31:0];
        if (v < Q32_MIN) return Q32_MIN[31:0];
        return v[31:0];
    endfunction

    function automatic logic signed [23:0] clamp_sample(input longint v);
        if (v > SMP_MAX) return SMP_MAX[23:0];
        if (v < SMP_MIN) return SMP_MIN[23:0];
        return v[23:0];
    endfunction

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 70) return 0;
        if (p < 95) return $urandom_range(1, 4);
        return $urandom_range(15, 60);
    endfunction

    function automatic logic [23:0] rand_sample();
        int p;
        p = $urandom_range(0, 99);
        if (p < 60) return 24'($urandom);
        if (p < 85) return 24'($urandom_range(0, 131071) - 65536);
        case ($urandom_range(0, 3))
            0: return S_MAX;
            1: return S_MIN;
            2: return 24'd0;
            default: return 24'hFFFFFF;
        endcase
    endfunction

    task automatic rotate(inout logic signed [31:0] s, inout logic signed [31:0] c,
                          input logic [23:0] rate);
        c = clamp32(longint'(c) - ((longint'(s) * longint'(rate)) >>> 24));
        s = clamp32(longint'(s) + ((longint'(c) * longint'(rate)) >>> 24));
    endtask

    task automatic filter_channel(input logic signed [23:0] smp, input longint f,
                                  inout logic signed [31:0] low,
                                  inout logic signed [31:0] band,
                                  output logic signed [23:0] res);
        longint x;
        longint high;
        longint sel;
        x    = longint'(smp) >>> 4;
        low  = clamp32(longint'(low) + ((f * longint'(band)) >>> 30));
        high = clamp32(((longint'(res_gain) * (x - longint'(band))) >>> 14) - longint'(low));
        band = clamp32(longint'(band) + ((f * high) >>> 30));
        case (out_mode)
            MODE_LOW:  sel = low;
            MODE_HIGH: sel = high;
            default:   sel = band;
        endcase
        res = clamp_sample(((longint'(dry_q14) * longint'(smp)) >>> 14) + sel * 16);
    endtask

    task automatic filter_pair(input logic [47:0] data, output logic [47:0] result);
        longint             sum;
        longint             f;
        logic signed [23:0] left;
        logic signed [23:0] right;
        rotate(sin_one, cos_one, rate_one);
        rotate(sin_two, cos_two, rate_two);
        sum = longint'(sin_one) + longint'(sin_two) + longint'(cut_hz) * 65536;
        f   = clamp32((sum * longint'(TUNE_COEF_Q32)) >>> 18);
        filter_channel(data[23:0], f, low_l, band_l, left);
        filter_channel(data[47:24], f, low_r, band_r, right);
        result = {right, left};
    endtask

    task automatic set_reg(input logic [2:0] idx, input logic [23:0] val);
        case (idx)
            REG_CUTOFF:     cut_hz   = val[14:0];
            REG_RESONANCE:  res_gain = val[15:0];
            REG_LFO1_RATE:  rate_one = val;
            REG_LFO1_DEPTH: cos_one  = {val[15:0], 16'h0};
            REG_LFO2_RATE:  rate_two = val;
            REG_LFO2_DEPTH: cos_two  = {val[15:0], 16'h0};
            REG_DRY_GAIN:   dry_q14  = val[15:0];
            REG_MODE:       out_mode = val[1:0];
            default: ;
        endcase
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        set_reg(idx, val);
        @(posedge aclk);
    endtask

    task automatic send_pair(input logic [47:0] data, input bit typed, input logic [47:0] known);
        logic [47:0] result;
        s_tdata  <= data;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        filter_pair(data, result);
        awaited_pairs.push_back(typed ? known : result);
    endtask

    task automatic pause(input int n);
        if (n > 0) begin
            s_tvalid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
    endtask

    task automatic drain();
        while (awaited_pairs.size() != 0) @(posedge aclk);
    endtask

    task automatic plan_cfg(input logic [2:0] idx, input logic [23:0] val);
        dir_row_t r;
        r = '{ROW_CFG, idx, val, 48'd0, 1'b0, 48'd0};
        plan.push_back(r);
    endtask

    task automatic plan_pair(input logic [23:0] left, input logic [23:0] right,
                             input bit typed = 1'b0, input logic [47:0] known = 48'd0);
        dir_row_t r;
        r = '{ROW_PAIR, 3'd0, 24'd0, {right, left}, typed, known};
        plan.push_back(r);
    endtask

    task automatic pick_settings();
        bit wild;
        wild = ($urandom_range(0, 4) == 0);
        if ($urandom_range(0, 9) < 6)
            write_reg(REG_CUTOFF, wild ? ($urandom_range(0, 1) ? 24'h7FFF : 24'($urandom))
                                       : 24'($urandom_range(20, 8000)));
        if ($urandom_range(0, 9) < 6)
            write_reg(REG_RESONANCE, wild ? ($urandom_range(0, 1) ? 24'hFFFF : 24'd0)
                                          : 24'($urandom_range(2048, 24576)));
        if ($urandom_range(0, 9) < 6)
            write_reg(REG_LFO1_RATE, wild ? 24'($urandom) : 24'($urandom_range(0, 65535)));
        if ($urandom_range(0, 9) < 6)
            write_reg(REG_LFO1_DEPTH, wild ? 24'($urandom)
                                           : 24'(int'($urandom_range(0, 8000)) - 4000));
        if ($urandom_range(0, 9) < 6)
            write_reg(REG_LFO2_RATE, wild ? 24'($urandom) : 24'($urandom_range(0, 65535)));
        if ($urandom_range(0, 9) < 6)
            write_reg(REG_LFO2_DEPTH, wild ? 24'($urandom)
                                           : 24'(int'($urandom_range(0, 8000)) - 4000));
        if ($urandom_range(0, 9) < 6)
            write_reg(REG_DRY_GAIN, wild ? ($urandom_range(0, 1) ? 24'h007FFF : 24'hFF8000)
                                         : 24'(int'($urandom_range(0, 32768)) - 16384));
        write_reg(REG_MODE, 24'($urandom_range(0, 3)));
    endtask

    // result side: check each transfer, stall at random, one long hold-off
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (awaited_pairs.size() == 0) begin
                    $error("unexpected result transfer: %h", m_tdata);
                    errors++;
                end else begin
                    want_pair = awaited_pairs.pop_front();
                    if (m_tdata[23:0] !== want_pair[23:0]) begin
                        $error("left_result: expected %0d, got %0d",
                               $signed(want_pair[23:0]), $signed(m_tdata[23:0]));
                        errors++;
                    end
                    if (m_tdata[47:24] !== want_pair[47:24]) begin
                        $error("right_result: expected %0d, got %0d",
                               $signed(want_pair[47:24]), $signed(m_tdata[47:24]));
                        errors++;
                    end
                end
            end
            if (!long_hold_done && results_seen == 40) begin
                hold_left      = 400;
                long_hold_done = 1'b1;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                if (calm_left != 0)
                    calm_left--;
                else if ($urandom_range(0, 199) == 0)
                    calm_left = 300;
                if (calm_left != 0 || stall_left == 0) begin
                    m_tready <= 1'b1;
                    if (calm_left == 0)
                        stall_left = gap_len();
                end else begin
                    stall_left--;
                    m_tready <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        dir_row_t row;
        bit       writing;
        bit       steady;

        // reset state: low-pass output of the first pair is zero
        plan_pair(S_MAX, S_MIN, 1'b1, 48'd0);
        plan_pair(S_MIN, S_MAX);
        plan_pair(24'd0, 24'd0);
        plan_pair(24'd1, 24'hFFFFFF);
        plan_pair(24'h555555, 24'hAAAAAA);
        plan_cfg(REG_MODE, 24'(MODE_HIGH));
        plan_pair(S_MAX, S_MAX);
        plan_pair(S_MIN, S_MIN);
        plan_cfg(REG_MODE, 24'(MODE_BAND));
        plan_pair(S_MAX, S_MIN);
        plan_pair(24'h0F0F0F, 24'hF0F0F0);
        plan_cfg(REG_MODE, 24'(MODE_BAND_ALT));
        plan_pair(S_MIN, S_MAX);
        plan_pair(24'h123456, 24'hEDCBA9);
        plan_cfg(REG_DRY_GAIN, 24'h007FFF);
        plan_cfg(REG_MODE, 24'(MODE_LOW));
        plan_pair(S_MAX, S_MIN);
        plan_pair(S_MIN, S_MAX);
        plan_cfg(REG_DRY_GAIN, 24'hFF8000);
        plan_pair(S_MAX, S_MIN);
        plan_pair(S_MIN, S_MAX);
        // drive the coefficient and the integrators into saturation
        plan_cfg(REG_CUTOFF, 24'h007FFF);
        plan_cfg(REG_RESONANCE, 24'h00FFFF);
        plan_cfg(REG_LFO1_RATE, 24'hFFFFFF);
        plan_cfg(REG_LFO1_DEPTH, 24'h007FFF);
        plan_cfg(REG_LFO2_RATE, 24'h800000);
        plan_cfg(REG_LFO2_DEPTH, 24'hFF8000);
        plan_cfg(REG_DRY_GAIN, 24'd0);
        plan_pair(S_MAX, S_MIN);
        plan_pair(S_MAX, S_MAX);
        plan_pair(S_MIN, S_MIN);
        plan_pair(24'd0, 24'd0);
        // reload the cosine mid-swing, sine keeps running
        plan_cfg(REG_LFO1_DEPTH, 24'h004000);
        plan_pair(24'h400000, 24'hC00000);
        plan_pair(24'h000100, 24'hFFFF00);
        plan_cfg(REG_CUTOFF, 24'd0);
        plan_cfg(REG_RESONANCE, 24'd0);
        plan_cfg(REG_LFO1_RATE, 24'd0);
        plan_cfg(REG_LFO2_RATE, 24'd0);
        plan_cfg(REG_LFO1_DEPTH, 24'd0);
        plan_cfg(REG_LFO2_DEPTH, 24'd0);
        plan_pair(S_MAX, S_MIN);
        plan_pair(24'h2AAAAA, 24'hD55555);

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        writing = 1'b0;
        foreach (plan[i]) begin
            row = plan[i];
            if (row.kind == ROW_CFG) begin
                if (!writing) begin
                    s_tvalid <= 1'b0;
                    drain();
                    writing = 1'b1;
                end
                write_reg(row.idx, row.value);
            end else begin
                if (writing) begin
                    cfg_we  <= 1'b0;
                    writing = 1'b0;
                end
                send_pair(row.data, row.typed, row.known);
                pause(gap_len());
            end
        end

        for (int ph = 0; ph < 10; ph++) begin
            s_tvalid <= 1'b0;
            drain();
            pick_settings();
            cfg_we <= 1'b0;
            steady = ($urandom_range(0, 3) == 0);
            repeat (65) begin
                send_pair({rand_sample(), rand_sample()}, 1'b0, 48'd0);
                if (!steady)
                    pause(gap_len());
            end
        end

        s_tvalid <= 1'b0;
        drain();
        repeat (40) @(posedge aclk);
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
